// ----- rtl/nap_pkg.sv -----
// shared types and constants for the nesting-aware pattern search
package nap_pkg;

  localparam int PatternMax = 8;
  localparam int DepthBits  = 16;
  localparam int PosBits    = 16;
  localparam int PatIdxBits = (PatternMax > 1) ? $clog2(PatternMax) : 1;
  localparam int LenBits    = 4;
  localparam int CfgBits    = 64;

  localparam logic [7:0] ChParOpen  = 8'h28;
  localparam logic [7:0] ChParClose = 8'h29;
  localparam logic [7:0] ChSqOpen   = 8'h5b;
  localparam logic [7:0] ChSqClose  = 8'h5d;
  localparam logic [7:0] ChCuOpen   = 8'h7b;
  localparam logic [7:0] ChCuClose  = 8'h7d;
  localparam logic [7:0] ChDQuote   = 8'h22;
  localparam logic [7:0] ChSQuote   = 8'h27;
  localparam logic [7:0] ChEscape   = 8'h5c;

  typedef enum logic [2:0] {
    SKIP_TOP    = 3'd0,
    SKIP_PAREN  = 3'd1,
    SKIP_SQUARE = 3'd2,
    SKIP_CURLY  = 3'd3,
    SKIP_DQUOTE = 3'd4,
    SKIP_SQUOTE = 3'd5
  } skip_mode_e;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_NONE     = 2'd1,
    ST_UNCLOSED = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic {
    CFG_PATTERN = 1'b0,
    CFG_LENGTH  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic advance;
    logic clear;
  } skip_ctrl_t;

  typedef struct packed {
    logic at_top;
    logic overflow;
    logic end_overflow;
    logic end_unclosed;
  } skip_stat_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctrl_t;

endpackage

// ----- rtl/nesting_aware_pattern_search_core.sv -----
// top level: window cell chain, skip tracker, match bookkeeping and result register
// latency: the result is valid in the cycle after the transfer of the last text byte
// throughput: one text byte per cycle unless stalled; the cell chain compare is combinational
// input is stalled only while a finished result is held and the output is stalled
// reset clears all text state, empties the result register, pattern to zero and length to one
// after each result the text state returns to its reset value; registers are kept
module nesting_aware_pattern_search_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_index_i,
  input  logic [nap_pkg::CfgBits-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       text_byte_i,
  input  logic                             last_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       search_status_o,
  output logic [nap_pkg::PosBits-1:0]      match_offset_o
);
  import nap_pkg::*;

  logic [CfgBits-1:0] pat_q;
  logic [LenBits-1:0] len_q;
  logic [LenBits-1:0] len_eff;

  logic               accept, run, hit, win_hit, first_flag;
  skip_ctrl_t         skip_ctrl;
  skip_stat_t         skip_stat;
  win_ctrl_t          win_ctrl;

  logic [7:0]         cell_in_byte [PatternMax];
  logic               cell_in_flag [PatternMax];
  logic [7:0]         cell_byte    [PatternMax];
  logic               cell_flag    [PatternMax];
  logic [7:0]         cell_want    [PatternMax];
  logic               cell_used    [PatternMax];
  logic [PatternMax-1:0] cell_hit;

  logic [PosBits-1:0] pos_q, pos_d, start;
  logic               found_q, found_d, found_n;
  logic [PosBits-1:0] off_q, off_d, off_n;

  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  logic [PosBits-1:0] res_off_q, res_off_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
      len_q <= LenBits'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PATTERN: pat_q <= cfg_data_i;
        CFG_LENGTH:  len_q <= cfg_data_i[LenBits-1:0];
        default:     pat_q <= pat_q;
      endcase
    end
  end

  assign len_eff = (len_q > LenBits'(PatternMax)) ? LenBits'(PatternMax) : len_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // cell chain
  assign win_ctrl.shift = accept;
  assign win_ctrl.clear = accept && last_byte_i;

  for (genvar i = 0; i < PatternMax; i++) begin : g_cell
    logic [LenBits-1:0] want_idx;

    if (i == 0) begin : g_head
      assign cell_in_byte[i] = text_byte_i;
      assign cell_in_flag[i] = skip_stat.at_top;
    end else begin : g_link
      assign cell_in_byte[i] = cell_byte[i-1];
      assign cell_in_flag[i] = cell_flag[i-1];
    end

    assign want_idx     = len_eff - LenBits'(i + 1);
    assign cell_used[i] = (LenBits'(i) < len_eff);
    assign cell_want[i] = pat_q[8*want_idx[PatIdxBits-1:0] +: 8];

    nap_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (win_ctrl),
      .byte_i (cell_in_byte[i]),
      .flag_i (cell_in_flag[i]),
      .want_i (cell_want[i]),
      .used_i (cell_used[i]),
      .byte_o (cell_byte[i]),
      .flag_o (cell_flag[i]),
      .hit_o  (cell_hit[i])
    );
  end

  // top-level flag of the first byte of the candidate
  always_comb begin
    first_flag = 1'b0;
    for (int k = 0; k < PatternMax; k++) begin
      if (len_eff == LenBits'(k + 1)) first_flag = cell_in_flag[k];
    end
  end

  assign win_hit = &cell_hit;
  assign hit     = (len_eff == '0) ? skip_stat.at_top : (win_hit && first_flag);
  assign start   = (len_eff == '0) ? pos_q
                 : pos_q + PosBits'(1) - PosBits'(len_eff);

  assign run               = !found_q && !skip_stat.overflow;
  assign skip_ctrl.advance = accept && run && !hit;
  assign skip_ctrl.clear   = accept && last_byte_i;

  nap_skip u_skip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (skip_ctrl),
    .byte_i (text_byte_i),
    .stat_o (skip_stat)
  );

  // match bookkeeping
  always_comb begin
    found_n = found_q;
    off_n   = off_q;
    if (accept && run && hit) begin
      found_n = 1'b1;
      off_n   = start;
    end
    pos_d   = pos_q;
    found_d = found_n;
    off_d   = off_n;
    if (accept) begin
      if (last_byte_i) begin
        pos_d   = '0;
        found_d = 1'b0;
        off_d   = '0;
      end else begin
        pos_d = pos_q + PosBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      found_q <= 1'b0;
      off_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      found_q <= found_d;
      off_q   <= off_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    res_off_d   = res_off_q;
    if (accept && last_byte_i) begin
      out_valid_d = 1'b1;
      res_off_d   = '0;
      if (found_n) begin
        status_d  = ST_FOUND;
        res_off_d = off_n;
      end else if (skip_stat.end_overflow) begin
        status_d = ST_OVERFLOW;
      end else if (skip_stat.end_unclosed) begin
        status_d = ST_UNCLOSED;
      end else begin
        status_d = ST_NONE;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    res_off_q <= res_off_d;
  end

  assign out_valid_o     = out_valid_q;
  assign search_status_o = status_q;
  assign match_offset_o  = res_off_q;

endmodule

// ----- rtl/nap_cell.sv -----
// one window cell: holds a text byte and its top-level flag, compares the incoming byte
module nap_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nap_pkg::win_ctrl_t ctrl_i,
  input  logic [7:0]        byte_i,
  input  logic              flag_i,
  input  logic [7:0]        want_i,
  input  logic              used_i,
  output logic [7:0]        byte_o,
  output logic              flag_o,
  output logic              hit_o
);
  import nap_pkg::*;

  logic [7:0] byte_q, byte_d;
  logic       flag_q, flag_d;

  always_comb begin
    byte_d = byte_q;
    flag_d = flag_q;
    if (ctrl_i.clear) begin
      byte_d = '0;
      flag_d = 1'b0;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
      flag_d = flag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
      flag_q <= 1'b0;
    end else begin
      byte_q <= byte_d;
      flag_q <= flag_d;
    end
  end

  // compare against the byte that moves in on this transfer
  assign hit_o  = !used_i || (byte_i == want_i);
  assign byte_o = byte_q;
  assign flag_o = flag_q;

endmodule

// ----- rtl/nap_skip.sv -----
// bracket and quote skip tracker with nesting depth and overflow flag
module nap_skip (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nap_pkg::skip_ctrl_t ctrl_i,
  input  logic [7:0]          byte_i,
  output nap_pkg::skip_stat_t stat_o
);
  import nap_pkg::*;

  skip_mode_e           mode_q, mode_d, mode_n;
  logic [DepthBits-1:0] depth_q, depth_d, depth_n;
  logic                 esc_q, esc_d, esc_n;
  logic                 ovf_q, ovf_d, ovf_n;
  logic [7:0]           opener, closer, quote;

  always_comb begin
    opener = ChParOpen;
    closer = ChParClose;
    quote  = ChDQuote;
    case (mode_q)
      SKIP_SQUARE: begin
        opener = ChSqOpen;
        closer = ChSqClose;
      end
      SKIP_CURLY: begin
        opener = ChCuOpen;
        closer = ChCuClose;
      end
      SKIP_SQUOTE: quote = ChSQuote;
      default: quote = ChDQuote;
    endcase
  end

  // state after this byte, before the end-of-text clear
  always_comb begin
    mode_n  = mode_q;
    depth_n = depth_q;
    esc_n   = esc_q;
    ovf_n   = ovf_q;
    if (ctrl_i.advance) begin
      case (mode_q)
        SKIP_TOP: begin
          if (byte_i == ChParOpen) begin
            mode_n  = SKIP_PAREN;
            depth_n = DepthBits'(1);
          end else if (byte_i == ChSqOpen) begin
            mode_n  = SKIP_SQUARE;
            depth_n = DepthBits'(1);
          end else if (byte_i == ChCuOpen) begin
            mode_n  = SKIP_CURLY;
            depth_n = DepthBits'(1);
          end else if (byte_i == ChDQuote) begin
            mode_n = SKIP_DQUOTE;
            esc_n  = 1'b0;
          end else if (byte_i == ChSQuote) begin
            mode_n = SKIP_SQUOTE;
            esc_n  = 1'b0;
          end
        end
        SKIP_PAREN, SKIP_SQUARE, SKIP_CURLY: begin
          if (byte_i == opener) begin
            if (&depth_q) ovf_n = 1'b1;
            else depth_n = depth_q + DepthBits'(1);
          end else if (byte_i == closer) begin
            if (depth_q <= DepthBits'(1)) begin
              depth_n = '0;
              mode_n  = SKIP_TOP;
            end else begin
              depth_n = depth_q - DepthBits'(1);
            end
          end
        end
        SKIP_DQUOTE, SKIP_SQUOTE: begin
          if (esc_q) esc_n = 1'b0;
          else if (byte_i == quote) mode_n = SKIP_TOP;
          else if (byte_i == ChEscape) esc_n = 1'b1;
        end
        default: begin
          mode_n  = SKIP_TOP;
          depth_n = '0;
          esc_n   = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (ctrl_i.clear) begin
      mode_d  = SKIP_TOP;
      depth_d = '0;
      esc_d   = 1'b0;
      ovf_d   = 1'b0;
    end else begin
      mode_d  = mode_n;
      depth_d = depth_n;
      esc_d   = esc_n;
      ovf_d   = ovf_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= SKIP_TOP;
      depth_q <= '0;
      esc_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      depth_q <= depth_d;
      esc_q   <= esc_d;
      ovf_q   <= ovf_d;
    end
  end

  assign stat_o.at_top       = (mode_q == SKIP_TOP);
  assign stat_o.overflow     = ovf_q;
  assign stat_o.end_overflow = ovf_n;
  assign stat_o.end_unclosed = (mode_n != SKIP_TOP);

endmodule
